[src/erse_pkg.sv]
// Shared types and constants for the echo range spike-reject filter.
// No dependencies; every module of the block imports this package.
package erse_pkg;

   localparam int PULSE_W    = 16;
   localparam int DIST_W     = 15;
   localparam int ALPHA_W    = 9;
   localparam int OUTCOME_W  = 2;
   localparam int RSP_DATA_W = 32;

   // floor(pulse * 8 / 29) == (pulse * ceil(2^24 / 29)) >> 21, exact for 16-bit pulses.
   localparam int RECIP_W    = 20;
   localparam logic [RECIP_W-1:0] DIV29_RECIP = RECIP_W'(578525);
   localparam int RECIP_SHIFT = 21;
   localparam int PROD_W     = PULSE_W + RECIP_W;

   localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);
   localparam logic [1:0] REJECT_LIMIT = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_JUMP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA     = 2'd2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PULSE_W-1:0] RESET_MAX_PULSE = PULSE_W'(30000);
   localparam logic [DIST_W-1:0]  RESET_MAX_JUMP  = DIST_W'(800);
   localparam logic [ALPHA_W-1:0] RESET_ALPHA     = ALPHA_W'(77);

   typedef logic [DIST_W-1:0] dist_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_NO_ECHO  = 2'd0,
      OUTCOME_SPIKE    = 2'd1,
      OUTCOME_ACCEPTED = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [PULSE_W-1:0] max_pulse_us;
      dist_type           max_jump;
      logic [ALPHA_W-1:0] ema_alpha;
   } cfg_type;

endpackage

[src/echo_range_spike_reject_ema_top.sv]
// Echo range filter: pulse width to distance, spike rejection, moving average.
// An accepted request beat passes the conversion register, the queue slot and the
// result register before its response beat; throughput one beat per cycle while
// rsp_tready is high. Reset (synchronous, active high) clears the queue, the filter
// state and response valid, and restores the register defaults 30000, 800 and 77.
// Depends on erse_pkg, erse_front, erse_queue and erse_back.
module echo_range_spike_reject_ema_top
   import erse_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PULSE_W-1:0]     req_tdata,   // [15:0] pulse_width_us
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [14:0] filtered_distance,
                                               // [29:15] raw_distance, [31:30] outcome
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The configuration registers. Writes to an index past the list are dropped.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_PULSE: cfg_in.max_pulse_us = csr_wdata;
            CSR_MAX_JUMP:  cfg_in.max_jump     = csr_wdata[DIST_W-1:0];
            CSR_ALPHA:     cfg_in.ema_alpha    = csr_wdata[ALPHA_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_pulse_us <= RESET_MAX_PULSE;
         cfg_ff.max_jump     <= RESET_MAX_JUMP;
         cfg_ff.ema_alpha    <= RESET_ALPHA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end converts each beat to a distance; zero stands for no echo,
   // so the queue only has to carry one 15-bit word per beat.
   logic     front_valid, front_ready;
   dist_type front_raw;
   logic     back_valid, back_ready;
   dist_type back_raw;

   erse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_raw   (front_raw)
   );

   // The queue lets the front keep taking beats while the response side stalls.
   erse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_raw),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_raw)
   );

   // The back end owns all filter state and updates it once per beat, so a
   // new beat can follow the previous one in the next cycle.
   erse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item_raw   (back_raw),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[src/erse_front.sv]
// Front end: accepts pulse beats, applies the echo timeout and converts the
// pulse width to distance. Depends on erse_pkg.
module erse_front
   import erse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [PULSE_W-1:0] req_tdata,
   output logic               item_valid,
   input  logic               item_ready,
   output dist_type           item_raw
);

   logic              valid_ff, valid_in;
   logic              echo_ff, echo_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      echo_in  = (req_tdata != '0) && (req_tdata <= cfg.max_pulse_us);
      prod_in  = PROD_W'(req_tdata) * PROD_W'(DIV29_RECIP);
      valid_in = take || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         echo_ff <= echo_in;
         prod_ff <= prod_in;
      end
   end

   // A conversion that truncates to zero is also no echo, and reads as zero here.
   assign item_valid = valid_ff;
   assign item_raw   = echo_ff ? prod_ff[RECIP_SHIFT +: DIST_W] : '0;

endmodule

[src/erse_queue.sv]
// Short queue of converted distances between the front and back ends.
// Depends on erse_pkg.
module erse_queue
   import erse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  dist_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output dist_type pop_data
);

   dist_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/erse_back.sv]
// Back end: spike test, reject counting and the moving-average update, with
// the result register that drives the response channel. Depends on erse_pkg.
module erse_back
   import erse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  dist_type              item_raw,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   dist_type    smooth_ff, smooth_in;
   dist_type    last_ff, last_in;
   logic [1:0]  rejects_ff, rejects_in;
   logic        seeded_ff, seeded_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dist_type    rsp_filt_ff, rsp_raw_ff;
   outcome_type rsp_outcome_ff, outcome_in;

   logic                      fire;
   dist_type                  jump;
   logic                      spike;
   logic [ALPHA_W-1:0]        alpha_sat;
   logic signed [DIST_W:0]    diff;
   logic signed [DIST_W+ALPHA_W+1:0] prod;
   logic signed [DIST_W+3:0]  next_val;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid && item_ready;

   always_comb begin
      jump      = (item_raw > last_ff) ? item_raw - last_ff : last_ff - item_raw;
      spike     = seeded_ff && (jump > cfg.max_jump) && (rejects_ff != REJECT_LIMIT);
      alpha_sat = (cfg.ema_alpha > ALPHA_MAX) ? ALPHA_MAX : cfg.ema_alpha;
      diff      = $signed({1'b0, item_raw}) - $signed({1'b0, smooth_ff});
      prod      = $signed({1'b0, alpha_sat}) * diff;
      // Arithmetic shift gives the floor of the division by 256.
      next_val  = $signed({4'b0000, smooth_ff})
                + (DIST_W+4)'(prod >>> 8);

      smooth_in  = smooth_ff;
      last_in    = last_ff;
      rejects_in = rejects_ff;
      seeded_in  = seeded_ff;
      outcome_in = OUTCOME_NO_ECHO;
      if (item_raw != '0) begin
         if (spike) begin
            rejects_in = rejects_ff + 2'd1;
            outcome_in = OUTCOME_SPIKE;
         end else begin
            rejects_in = '0;
            last_in    = item_raw;
            seeded_in  = 1'b1;
            outcome_in = OUTCOME_ACCEPTED;
            if (!seeded_ff) begin
               smooth_in = item_raw;
            end else if (next_val < 0) begin
               smooth_in = '0;
            end else begin
               smooth_in = next_val[DIST_W-1:0];
            end
         end
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= '0;
         last_ff      <= '0;
         rejects_ff   <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            smooth_ff  <= smooth_in;
            last_ff    <= last_in;
            rejects_ff <= rejects_in;
            seeded_ff  <= seeded_in;
         end
      end
      if (fire) begin
         rsp_filt_ff    <= smooth_in;
         rsp_raw_ff     <= item_raw;
         rsp_outcome_ff <= outcome_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_outcome_ff, rsp_raw_ff, rsp_filt_ff};

endmodule

[src/erse_checker.sv]
// Port-level checks on the response channel of the echo range filter.
// Depends on erse_pkg; bound to echo_range_spike_reject_ema_top.
module erse_checker
   import erse_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_no_echo_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:30] == OUTCOME_NO_ECHO |-> rsp_tdata[29:15] == '0)
      else $error("no-echo beat carries a distance");

   a_echo_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[31:30] == OUTCOME_SPIKE
                     || rsp_tdata[31:30] == OUTCOME_ACCEPTED) |-> rsp_tdata[29:15] != '0)
      else $error("echo beat carries a zero distance");

endmodule

bind echo_range_spike_reject_ema_top erse_checker u_erse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
